// ===== hw/rtl/hsv2rgb_pkg.sv =====
// Package for the HSV to RGB converter: shared constants, hue sector codes
// and the payload structs that travel between pipeline stages.
// No dependencies.
package hsv2rgb_pkg;

    localparam int unsigned HueW      = 9;
    localparam int unsigned PctW      = 7;
    localparam int unsigned FracW     = 6;
    localparam int unsigned CoefW     = 13;
    localparam int unsigned ProdW     = 20;
    localparam int unsigned SumW      = 24;
    localparam int unsigned DivShift  = 6;
    localparam int unsigned ScaledW   = SumW - DivShift;
    localparam int unsigned RecipW    = 19;
    localparam int unsigned RecipShift = 28;
    localparam int unsigned ChanW     = 8;

    localparam logic [HueW-1:0]    FULL_CIRCLE = 9'd360;
    localparam logic [HueW-1:0]    DEG_SECTOR  = 9'd60;
    localparam logic [PctW-1:0]    PCT_FULL    = 7'd100;
    localparam logic [FracW-1:0]   FRAC_FULL   = 6'd60;
    localparam logic [CoefW-1:0]   COEF_FULL   = 13'd6000;
    localparam logic [FracW-1:0]   COEF_STEP   = 6'd60;
    localparam logic [SumW-1:0]    ROUND_OFS   = 24'd20000;
    localparam logic [RecipW-1:0]  RECIP_MUL   = 19'd429497;

    typedef enum logic [2:0] {
        SEC_RED_YELLOW,
        SEC_YELLOW_GREEN,
        SEC_GREEN_CYAN,
        SEC_CYAN_BLUE,
        SEC_BLUE_MAGENTA,
        SEC_MAGENTA_RED
    } t_sector;

    typedef struct packed {
        t_sector             sector;
        logic [FracW-1:0]    frac;
        logic [PctW-1:0]     sat;
        logic [PctW-1:0]     bri;
    } t_norm;

    typedef struct packed {
        logic [PctW-1:0]     bri;
        logic [CoefW-1:0]    a_r;
        logic [CoefW-1:0]    a_g;
        logic [CoefW-1:0]    a_b;
    } t_coef;

    typedef struct packed {
        logic [ProdW-1:0]    x_r;
        logic [ProdW-1:0]    x_g;
        logic [ProdW-1:0]    x_b;
    } t_prod;

    typedef struct packed {
        logic [ScaledW-1:0]  z_r;
        logic [ScaledW-1:0]  z_g;
        logic [ScaledW-1:0]  z_b;
    } t_scaled;

    typedef struct packed {
        logic [ChanW-1:0]    blue;
        logic [ChanW-1:0]    green;
        logic [ChanW-1:0]    red;
    } t_rgb;

endpackage

// ===== hw/rtl/hsv2rgb_norm.sv =====
// First pipeline stage: wraps the hue, saturates saturation and brightness,
// and splits the hue into sector and fraction. Depends on hsv2rgb_pkg.
module hsv2rgb_norm (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [hsv2rgb_pkg::HueW-1:0]   i_hue,
    input  logic [hsv2rgb_pkg::PctW-1:0]   i_sat,
    input  logic [hsv2rgb_pkg::PctW-1:0]   i_bri,
    output logic                           o_valid,
    input  logic                           i_ready,
    output hsv2rgb_pkg::t_norm             o_data
);
    import hsv2rgb_pkg::*;

    logic             r_vld;
    t_norm            r_data;
    t_norm            n_data;
    logic [HueW-1:0]  hue_w;
    logic [HueW-1:0]  base;
    logic [HueW-1:0]  frac_w;

    always_comb begin
        hue_w = (i_hue >= FULL_CIRCLE) ? (i_hue - FULL_CIRCLE) : i_hue;
        priority if (hue_w < DEG_SECTOR) begin
            n_data.sector = SEC_RED_YELLOW;
            base = '0;
        end else if (hue_w < 2 * DEG_SECTOR) begin
            n_data.sector = SEC_YELLOW_GREEN;
            base = DEG_SECTOR;
        end else if (hue_w < 3 * DEG_SECTOR) begin
            n_data.sector = SEC_GREEN_CYAN;
            base = HueW'(2 * DEG_SECTOR);
        end else if (hue_w < 4 * DEG_SECTOR) begin
            n_data.sector = SEC_CYAN_BLUE;
            base = HueW'(3 * DEG_SECTOR);
        end else if (hue_w < 5 * DEG_SECTOR) begin
            n_data.sector = SEC_BLUE_MAGENTA;
            base = HueW'(4 * DEG_SECTOR);
        end else begin
            n_data.sector = SEC_MAGENTA_RED;
            base = HueW'(5 * DEG_SECTOR);
        end
        frac_w      = hue_w - base;
        n_data.frac = frac_w[FracW-1:0];
        n_data.sat  = (i_sat > PCT_FULL) ? PCT_FULL : i_sat;
        n_data.bri  = (i_bri > PCT_FULL) ? PCT_FULL : i_bri;
    end

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== hw/rtl/hsv2rgb_coef.sv =====
// Second pipeline stage: forms the p, q, t and v coefficients over the
// fraction and routes them to the channels by sector. Depends on hsv2rgb_pkg.
module hsv2rgb_coef (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  hsv2rgb_pkg::t_norm   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output hsv2rgb_pkg::t_coef   o_data
);
    import hsv2rgb_pkg::*;

    logic              r_vld;
    t_coef             r_data;
    t_coef             n_data;
    logic [CoefW-1:0]  sf;
    logic [CoefW-1:0]  st;
    logic [CoefW-1:0]  c_p;
    logic [CoefW-1:0]  c_q;
    logic [CoefW-1:0]  c_t;
    logic [FracW-1:0]  frac_inv;
    logic [PctW-1:0]   sat_inv;

    always_comb begin
        frac_inv = FRAC_FULL - i_data.frac;
        sat_inv  = PCT_FULL - i_data.sat;
        sf       = CoefW'(i_data.sat) * CoefW'(i_data.frac);
        st       = CoefW'(i_data.sat) * CoefW'(frac_inv);
        c_q      = COEF_FULL - sf;
        c_t      = COEF_FULL - st;
        c_p      = CoefW'(sat_inv) * CoefW'(COEF_STEP);
        n_data.bri = i_data.bri;
        unique case (i_data.sector)
            SEC_RED_YELLOW: begin
                n_data.a_r = COEF_FULL; n_data.a_g = c_t; n_data.a_b = c_p;
            end
            SEC_YELLOW_GREEN: begin
                n_data.a_r = c_q; n_data.a_g = COEF_FULL; n_data.a_b = c_p;
            end
            SEC_GREEN_CYAN: begin
                n_data.a_r = c_p; n_data.a_g = COEF_FULL; n_data.a_b = c_t;
            end
            SEC_CYAN_BLUE: begin
                n_data.a_r = c_p; n_data.a_g = c_q; n_data.a_b = COEF_FULL;
            end
            SEC_BLUE_MAGENTA: begin
                n_data.a_r = c_t; n_data.a_g = c_p; n_data.a_b = COEF_FULL;
            end
            default: begin
                n_data.a_r = COEF_FULL; n_data.a_g = c_p; n_data.a_b = c_q;
            end
        endcase
    end

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== hw/rtl/hsv2rgb_mult.sv =====
// Third and fourth pipeline stages: multiplies each coefficient by the brightness,
// scales by 17, adds the rounding offset and divides by 64. Depends on hsv2rgb_pkg.
module hsv2rgb_mult (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  hsv2rgb_pkg::t_coef     i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output hsv2rgb_pkg::t_scaled   o_data
);
    import hsv2rgb_pkg::*;

    logic             r_vld_a;
    logic             r_vld_b;
    logic             rdy_a;
    logic             rdy_b;
    t_prod            r_prod;
    t_prod            n_prod;
    t_scaled          r_data;
    t_scaled          n_data;
    logic [SumW-1:0]  y_r;
    logic [SumW-1:0]  y_g;
    logic [SumW-1:0]  y_b;

    always_comb begin
        n_prod.x_r = ProdW'(i_data.bri) * ProdW'(i_data.a_r);
        n_prod.x_g = ProdW'(i_data.bri) * ProdW'(i_data.a_g);
        n_prod.x_b = ProdW'(i_data.bri) * ProdW'(i_data.a_b);
    end

    always_comb begin
        y_r = (SumW'(r_prod.x_r) << 4) + SumW'(r_prod.x_r) + ROUND_OFS;
        y_g = (SumW'(r_prod.x_g) << 4) + SumW'(r_prod.x_g) + ROUND_OFS;
        y_b = (SumW'(r_prod.x_b) << 4) + SumW'(r_prod.x_b) + ROUND_OFS;
        n_data.z_r = y_r[SumW-1:DivShift];
        n_data.z_g = y_g[SumW-1:DivShift];
        n_data.z_b = y_b[SumW-1:DivShift];
    end

    assign rdy_b   = !r_vld_b || i_ready;
    assign rdy_a   = !r_vld_a || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_vld_b;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_vld_a <= i_valid;
            end
            if (rdy_b) begin
                r_vld_b <= r_vld_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_prod <= n_prod;
        end
        if (rdy_b && r_vld_a) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== hw/rtl/hsv2rgb_round.sv =====
// Last pipeline stage and output register: divides the scaled sums by 625
// through a reciprocal multiply. Depends on hsv2rgb_pkg.
module hsv2rgb_round (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  hsv2rgb_pkg::t_scaled   i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output hsv2rgb_pkg::t_rgb      o_data
);
    import hsv2rgb_pkg::*;

    localparam int unsigned MulW = ScaledW + RecipW;

    logic             r_vld;
    t_rgb             r_data;
    t_rgb             n_data;
    logic [MulW-1:0]  m_r;
    logic [MulW-1:0]  m_g;
    logic [MulW-1:0]  m_b;

    always_comb begin
        m_r = MulW'(i_data.z_r) * MulW'(RECIP_MUL);
        m_g = MulW'(i_data.z_g) * MulW'(RECIP_MUL);
        m_b = MulW'(i_data.z_b) * MulW'(RECIP_MUL);
        n_data.red   = m_r[RecipShift +: ChanW];
        n_data.green = m_g[RecipShift +: ChanW];
        n_data.blue  = m_b[RecipShift +: ChanW];
    end

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== hw/rtl/hsv_to_rgb_converter_top.sv =====
// Top level of the HSV to RGB converter: chains the normalize, coefficient,
// multiply and rounding stages. Depends on hsv2rgb_pkg and the hsv2rgb_* stages.
//
// The slave stream takes one color per transaction: hue in degrees, saturation
// and brightness in percent. The master stream gives one transaction of 8-bit
// red, green and blue for each input transaction, in the same order.
// An accepted input passes the normalize, coefficient, product, scaled and
// output registers in that order. Throughput is one transaction per cycle
// without a receiver stall; the five register stages each take one per cycle.
// Every stage holds a valid bit and takes new data when it is empty or when
// the stage after it moves on, so a receiver stall fills the empty stages
// first and then drops o_s_axis_tready; nothing is lost or repeated.
// A hue of 360 to 511 wraps by 360, and saturation or brightness above 100
// is treated as 100.
// Reset clears all valid bits; the block then accepts input at once.
module hsv_to_rgb_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // hue [8:0], saturation [15:9], brightness [22:16], zero [23]
    input  logic [23:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    output logic [23:0] o_m_axis_tdata
);
    import hsv2rgb_pkg::*;

    logic     vld_norm;
    logic     rdy_norm;
    t_norm    d_norm;
    logic     vld_coef;
    logic     rdy_coef;
    t_coef    d_coef;
    logic     vld_mult;
    logic     rdy_mult;
    t_scaled  d_mult;
    t_rgb     d_rgb;

    hsv2rgb_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_hue   (i_s_axis_tdata[8:0]),
        .i_sat   (i_s_axis_tdata[15:9]),
        .i_bri   (i_s_axis_tdata[22:16]),
        .o_valid (vld_norm),
        .i_ready (rdy_norm),
        .o_data  (d_norm)
    );

    hsv2rgb_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vld_norm),
        .o_ready (rdy_norm),
        .i_data  (d_norm),
        .o_valid (vld_coef),
        .i_ready (rdy_coef),
        .o_data  (d_coef)
    );

    hsv2rgb_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vld_coef),
        .o_ready (rdy_coef),
        .i_data  (d_coef),
        .o_valid (vld_mult),
        .i_ready (rdy_mult),
        .o_data  (d_mult)
    );

    hsv2rgb_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vld_mult),
        .o_ready (rdy_mult),
        .i_data  (d_mult),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (d_rgb)
    );

    assign o_m_axis_tdata = d_rgb;

endmodule

// ===== hw/rtl/hsv2rgb_checker.sv =====
// Port-level checker for the HSV to RGB converter, bound to the top level.
// Depends only on the top level's ports.
module hsv2rgb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_s_axis_tready,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [23:0] o_m_axis_tdata
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Output transaction shown right after reset.");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("Input stalled while the output stage is empty.");

    a_sink_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("Input stalled while the receiver is ready.");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("Stalled output transaction changed.");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_hsv2rgb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
